FILE: design/assert_macros.svh
// Assertion macros used by the top-level RTL file of the channel deframer.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: design/crsf_pkg.sv
// Types, constants and register codes for the RC channel deframer.
// No dependencies; used by every module of the block.
`default_nettype none

package crsf_pkg;

    localparam int MAX_FRAME_LEN = 28;
    localparam int MIN_FRAME_LEN = 2;
    localparam int MIN_CHAN_LEN  = 4;
    localparam int LEN_W         = $clog2(MAX_FRAME_LEN + 1);
    localparam int IDX_W         = $clog2(MAX_FRAME_LEN + 3);

    localparam int CHAN_W = 11;
    localparam int STEER_W = 12;
    localparam int THR_W   = 11;
    localparam int TIME_W  = 16;

    localparam logic [7:0]        SYNC_RESET     = 8'hC8;
    localparam logic [7:0]        CHANNELS_RESET = 8'h16;
    localparam logic [TIME_W-1:0] TIMEOUT_RESET  = 16'd500;
    localparam logic [TIME_W-1:0] ELAPSED_MAX    = 16'hFFFF;

    localparam logic [IDX_W-1:0] IDX_LEN  = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_KIND = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_PAY0 = IDX_W'(3);
    localparam logic [IDX_W-1:0] IDX_PAY1 = IDX_W'(4);
    localparam logic [IDX_W-1:0] IDX_PAY2 = IDX_W'(5);

    localparam int CH_MIN  = 172;
    localparam int CH_MAX  = 1811;
    localparam int CH_SPAN = CH_MAX - CH_MIN;
    localparam int US_MIN  = 1000;
    localparam int US_MAX  = 2000;
    localparam int US_SPAN = US_MAX - US_MIN;
    localparam int US_NEUTRAL  = 1500;
    localparam int STEER_OFFSET = 1500;

    // floor(d * US_SPAN / CH_SPAN) == (d * MAP_RECIP) >> MAP_SHIFT for all 11-bit d
    localparam int MAP_SHIFT = 22;
    localparam longint unsigned MAP_RECIP =
        ((longint'(US_SPAN) << MAP_SHIFT) + longint'(CH_SPAN) - 1) / longint'(CH_SPAN);
    localparam int PROD_W = CHAN_W + MAP_SHIFT;

    typedef enum logic [1:0] {
        REG_SYNC     = 2'd0,
        REG_CHANNELS = 2'd1,
        REG_TIMEOUT  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [7:0]        sync_byte;
        logic [7:0]        channels_type;
        logic [TIME_W-1:0] timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [STEER_W-1:0] steering_us;
        logic [THR_W-1:0]   throttle_us;
        logic               frame_accepted;
        logic               failsafe;
    } out_item_t;

endpackage

`default_nettype wire

FILE: design/crsf_cfg.sv
// APB-style configuration registers: sync byte, channels type, timeout.
// Depends on crsf_pkg.
`default_nettype none

module crsf_cfg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output crsf_pkg::cfg_t    cfg
);
    import crsf_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx   = reg_idx_t'(paddr[3:2]);
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_byte     <= SYNC_RESET;
            cfg_reg.channels_type <= CHANNELS_RESET;
            cfg_reg.timeout_ms    <= TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_SYNC:     cfg_reg.sync_byte     <= pwdata[7:0];
                REG_CHANNELS: cfg_reg.channels_type <= pwdata[7:0];
                REG_TIMEOUT:  cfg_reg.timeout_ms    <= pwdata[TIME_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SYNC:     prdata = {24'd0, cfg_reg.sync_byte};
            REG_CHANNELS: prdata = {24'd0, cfg_reg.channels_type};
            REG_TIMEOUT:  prdata = {{(32 - TIME_W){1'b0}}, cfg_reg.timeout_ms};
            default:      prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

FILE: design/crsf_map.sv
// Maps one 11-bit channel value from 172..1811 onto 1000..2000 us, clamped.
// Depends on crsf_pkg; division by the span is a reciprocal multiply.
`default_nettype none

module crsf_map (
    input  wire logic [crsf_pkg::CHAN_W-1:0] raw,
    output logic [crsf_pkg::THR_W-1:0]       pulse_us
);
    import crsf_pkg::*;

    logic [CHAN_W-1:0] delta;
    logic [PROD_W-1:0] prod;
    logic [CHAN_W-1:0] quot;
    logic [CHAN_W-1:0] quot_clamped;

    always_comb
    begin
        delta = raw - CHAN_W'(CH_MIN);
        prod  = PROD_W'(delta) * PROD_W'(MAP_RECIP);
        quot  = prod[PROD_W-1:MAP_SHIFT];
        if (raw <= CHAN_W'(CH_MIN))
            quot_clamped = '0;
        else if (quot > CHAN_W'(US_SPAN))
            quot_clamped = CHAN_W'(US_SPAN);
        else
            quot_clamped = quot;
        pulse_us = THR_W'(US_MIN) + THR_W'(quot_clamped);
    end

endmodule

`default_nettype wire

FILE: design/crsf_deframer.sv
// Frame state, channel decode, failsafe timer and pulse width state.
// One transaction is folded into the state per step. Depends on crsf_pkg, crsf_map.
`default_nettype none

module crsf_deframer (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire crsf_pkg::cfg_t      cfg,
    input  wire logic                step,
    input  wire crsf_pkg::in_item_t  item,
    output crsf_pkg::out_item_t      result_next
);
    import crsf_pkg::*;

    logic [IDX_W-1:0]   idx_reg, idx_next, idx_inc;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [7:0]         kind_reg, kind_next;
    logic [7:0]         pay0_reg, pay1_reg, pay2_reg;
    logic [7:0]         pay0_next, pay1_next, pay2_next;
    logic [7:0]         pay2_cur;
    logic [TIME_W-1:0]  elapsed_reg, elapsed_next;
    logic [STEER_W-1:0] steer_reg, steer_next;
    logic [THR_W-1:0]   thr_reg, thr_next;
    logic [THR_W-1:0]   ch1_us, ch2_us;
    logic               accepted;
    logic               fs;

    assign pay2_cur = (idx_reg == IDX_PAY2) ? item.rx_byte : pay2_reg;

    crsf_map u_map_steer (
        .raw      ({pay1_reg[2:0], pay0_reg}),
        .pulse_us (ch1_us)
    );

    crsf_map u_map_thr (
        .raw      ({pay2_cur[5:0], pay1_reg[7:3]}),
        .pulse_us (ch2_us)
    );

    always_comb
    begin
        idx_next     = idx_reg;
        len_next     = len_reg;
        kind_next    = kind_reg;
        pay0_next    = pay0_reg;
        pay1_next    = pay1_reg;
        pay2_next    = pay2_reg;
        elapsed_next = elapsed_reg;
        steer_next   = steer_reg;
        thr_next     = thr_reg;
        accepted     = 1'b0;
        idx_inc      = idx_reg + IDX_W'(1);

        if (!item.func)
        begin
            if (idx_reg != '0 || item.rx_byte == cfg.sync_byte)
            begin
                if (idx_reg == IDX_LEN)
                begin
                    if (item.rx_byte < 8'(MIN_FRAME_LEN) || item.rx_byte > 8'(MAX_FRAME_LEN))
                        idx_next = '0;
                    else
                    begin
                        len_next = item.rx_byte[LEN_W-1:0];
                        idx_next = idx_inc;
                    end
                end
                else
                begin
                    if (idx_reg == IDX_KIND)
                        kind_next = item.rx_byte;
                    if (idx_reg == IDX_PAY0)
                        pay0_next = item.rx_byte;
                    if (idx_reg == IDX_PAY1)
                        pay1_next = item.rx_byte;
                    if (idx_reg == IDX_PAY2)
                        pay2_next = item.rx_byte;
                    idx_next = idx_inc;
                    if (idx_reg >= IDX_KIND && idx_inc == IDX_W'(len_reg) + IDX_W'(2))
                    begin
                        idx_next = '0;
                        if (kind_reg == cfg.channels_type && len_reg >= LEN_W'(MIN_CHAN_LEN))
                        begin
                            steer_next   = {ch1_us, 1'b0} - STEER_W'(STEER_OFFSET);
                            thr_next     = ch2_us;
                            elapsed_next = '0;
                            accepted     = 1'b1;
                        end
                    end
                end
            end
        end
        else if (elapsed_reg != ELAPSED_MAX)
            elapsed_next = elapsed_reg + TIME_W'(1);

        fs = elapsed_next > cfg.timeout_ms;
        if (fs)
            thr_next = THR_W'(US_NEUTRAL);

        result_next.steering_us    = steer_next;
        result_next.throttle_us    = thr_next;
        result_next.frame_accepted = accepted;
        result_next.failsafe       = fs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            len_reg     <= '0;
            kind_reg    <= '0;
            elapsed_reg <= '0;
            steer_reg   <= STEER_W'(US_NEUTRAL);
            thr_reg     <= THR_W'(US_NEUTRAL);
        end
        else if (step)
        begin
            idx_reg     <= idx_next;
            len_reg     <= len_next;
            kind_reg    <= kind_next;
            elapsed_reg <= elapsed_next;
            steer_reg   <= steer_next;
            thr_reg     <= thr_next;
        end
    end

    // payload bytes are only read once written
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            pay0_reg <= pay0_next;
            pay1_reg <= pay1_next;
            pay2_reg <= pay2_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/crsf_channel_deframer_pwm_top.sv
// Top level of the RC channel deframer: input register, deframer, result register.
// Depends on crsf_pkg, crsf_cfg, crsf_deframer and assert_macros.svh.
//
// Usage:
//   item / item_valid / item_ready carry one transaction per serial byte
//   (func = 0) or per millisecond tick (func = 1). Every transaction gives
//   exactly one result on result / result_valid / result_ready: current
//   steering and throttle pulse widths, a frame-complete flag and failsafe.
//   result_valid rises once the transaction has moved from the input register
//   into the result register. One transaction is taken per cycle while the
//   receiver takes results, the frame state being updated between the input
//   register and the result register.
//   A stalled receiver holds the result register; the input register then
//   fills and item_ready drops until the result is taken.
//   Reset empties both registers, clears the frame state and timer, sets both
//   pulse widths to 1500 us and loads the register defaults (sync 0xC8,
//   channels type 0x16, timeout 500 ms). Registers at byte addresses 0, 4, 8
//   are to be written through the APB port only while the block is idle; the block does not enforce it.
`default_nettype none
`include "assert_macros.svh"

module crsf_channel_deframer_pwm_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire crsf_pkg::in_item_t   item,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output crsf_pkg::out_item_t       result,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [3:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import crsf_pkg::*;

    cfg_t      cfg;
    logic      in_vld_reg;
    in_item_t  in_item_reg;
    logic      out_vld_reg;
    out_item_t out_item_reg;
    out_item_t result_next;
    logic      advance;

    assign pready       = 1'b1;
    assign advance      = in_vld_reg && (!out_vld_reg || result_ready);
    assign item_ready   = !in_vld_reg || advance;
    assign result_valid = out_vld_reg;
    assign result       = out_item_reg;

    crsf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    crsf_deframer u_deframer (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .step        (advance),
        .item        (in_item_reg),
        .result_next (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;
            if (advance)
                out_vld_reg <= 1'b1;
            else if (result_ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            in_item_reg <= item;
        if (advance)
            out_item_reg <= result_next;
    end

    `ASSERT_IMPLIES(a_fs_neutral, clk, rst_n, out_vld_reg && out_item_reg.failsafe, out_item_reg.throttle_us == THR_W'(US_NEUTRAL))
    `ASSERT_IMPLIES(a_frame_clears_fs, clk, rst_n, out_vld_reg && out_item_reg.frame_accepted, !out_item_reg.failsafe)
    `ASSERT_IMPLIES(a_full_stall, clk, rst_n, in_vld_reg && out_vld_reg && !result_ready, !item_ready)
    `ASSERT_NEXT(a_advance_fills, clk, rst_n, advance, out_vld_reg)

endmodule

`default_nettype wire

FILE: bench/crsf_channel_deframer_pwm_checker.sv
`timescale 1ns / 100ps
// Transaction checker for the RC channel deframer: tracks register writes, predicts
// every result from the accepted input transactions and compares it field by field.
// Depends on crsf_pkg; also holds the small bench package with the input codes.

package crsf_bench_pkg;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

endpackage

module crsf_channel_deframer_pwm_checker
    import crsf_pkg::*;
    import crsf_bench_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  in_item_t    item,
    input  logic        result_valid,
    input  logic        result_ready,
    input  out_item_t   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          mismatches,
    output int          pending,
    output int          results_seen,
    output int          frames_seen,
    output int          failsafe_seen
);

    localparam int RAW_LO = 172;
    localparam int RAW_HI = 1811;
    localparam int PW_LO = 1000;
    localparam int PW_HI = 2000;
    localparam int PW_MID = 1500;
    localparam int STEER_LO = 500;
    localparam int LEN_LO = 2;
    localparam int LEN_HI = 28;
    localparam int CHAN_FRAME_MIN = 4;
    localparam logic [15:0] ELAPSED_TOP = 16'hFFFF;

    logic [7:0]  sync_cfg;
    logic [7:0]  kind_cfg;
    logic [15:0] timeout_cfg;

    logic [4:0]  frame_pos;
    logic [4:0]  frame_len;
    logic [7:0]  frame_code;
    logic [7:0]  payload [3];
    logic [15:0] elapsed;
    logic [11:0] steer_pw;
    logic [10:0] throttle_pw;

    out_item_t   awaited [$];
    int          error_total;
    int          checked_total;
    int          frame_total;
    int          fs_total;

    function automatic int pulse_from_raw(input logic [10:0] raw);
        int v;
        v = ((int'(raw) - RAW_LO) * (PW_HI - PW_LO)) / (RAW_HI - RAW_LO) + PW_LO;
        if (v < PW_LO)
            v = PW_LO;
        if (v > PW_HI)
            v = PW_HI;
        return v;
    endfunction

    task automatic step_deframer(input in_item_t it, output out_item_t res);
        logic        hit;
        logic        drop;
        logic        fs;
        logic [10:0] ch_a;
        logic [10:0] ch_b;
        hit = 1'b0;
        drop = 1'b0;
        if (it.func == FUNC_TICK)
        begin
            if (elapsed != ELAPSED_TOP)
                elapsed++;
        end
        else if (!(frame_pos == 0 && it.rx_byte != sync_cfg))
        begin
            if (frame_pos == 1)
            begin
                if (it.rx_byte < LEN_LO || it.rx_byte > LEN_HI)
                begin
                    frame_pos = 0;
                    drop = 1'b1;
                end
                else
                    frame_len = it.rx_byte[4:0];
            end
            else if (frame_pos == 2)
                frame_code = it.rx_byte;
            else if (frame_pos >= 3 && frame_pos <= 5)
                payload[frame_pos - 3] = it.rx_byte;
            if (!drop)
            begin
                frame_pos++;
                if (frame_pos > 2 && int'(frame_pos) == int'(frame_len) + 2)
                begin
                    // short channels frames are dropped without touching the timer
                    if (frame_code == kind_cfg && frame_len >= CHAN_FRAME_MIN)
                    begin
                        ch_a = {payload[1][2:0], payload[0]};
                        ch_b = {payload[2][5:0], payload[1][7:3]};
                        steer_pw = 12'((pulse_from_raw(ch_a) - PW_LO) * 2 + STEER_LO);
                        throttle_pw = 11'(pulse_from_raw(ch_b));
                        elapsed = '0;
                        hit = 1'b1;
                    end
                    frame_pos = 0;
                end
            end
        end
        fs = elapsed > timeout_cfg;
        if (fs)
            throttle_pw = 11'(PW_MID);
        res.steering_us = steer_pw;
        res.throttle_us = throttle_pw;
        res.frame_accepted = hit;
        res.failsafe = fs;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        out_item_t got;
        if (!rst_n)
        begin
            sync_cfg = 8'hC8;
            kind_cfg = 8'h16;
            timeout_cfg = 16'd500;
            frame_pos = '0;
            frame_len = '0;
            frame_code = '0;
            payload[0] = '0;
            payload[1] = '0;
            payload[2] = '0;
            elapsed = '0;
            steer_pw = 12'(PW_MID);
            throttle_pw = 11'(PW_MID);
            awaited.delete();
            error_total = 0;
            checked_total = 0;
            frame_total = 0;
            fs_total = 0;
            mismatches <= 0;
            pending <= 0;
            results_seen <= 0;
            frames_seen <= 0;
            failsafe_seen <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_SYNC:     sync_cfg = pwdata[7:0];
                    REG_CHANNELS: kind_cfg = pwdata[7:0];
                    REG_TIMEOUT:  timeout_cfg = pwdata[15:0];
                    default:      ;
                endcase
            end
            if (result_valid && result_ready)
            begin
                checked_total++;
                if (result.frame_accepted)
                    frame_total++;
                if (result.failsafe)
                    fs_total++;
                if (awaited.size() == 0)
                begin
                    error_total++;
                    if (error_total <= 10)
                        $display("%0t: result with none awaited: steer %0d thr %0d acc %0b fs %0b",
                                 $realtime, result.steering_us, result.throttle_us,
                                 result.frame_accepted, result.failsafe);
                end
                else
                begin
                    want = awaited.pop_front();
                    if (want.steering_us !== result.steering_us
                        || want.throttle_us !== result.throttle_us
                        || want.frame_accepted !== result.frame_accepted
                        || want.failsafe !== result.failsafe)
                    begin
                        error_total++;
                        if (error_total <= 10)
                            $display("%0t: mismatch: expected steer %0d thr %0d acc %0b fs %0b, got steer %0d thr %0d acc %0b fs %0b",
                                     $realtime, want.steering_us, want.throttle_us,
                                     want.frame_accepted, want.failsafe,
                                     result.steering_us, result.throttle_us,
                                     result.frame_accepted, result.failsafe);
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                step_deframer(item, got);
                awaited.push_back(got);
            end
            mismatches <= error_total;
            pending <= awaited.size();
            results_seen <= checked_total;
            frames_seen <= frame_total;
            failsafe_seen <= fs_total;
        end
    end

endmodule

FILE: bench/crsf_channel_deframer_pwm_top_test.sv
`timescale 1ns / 100ps
// Testbench top for the RC channel deframer: clock, reset, register writes, byte and
// tick stimulus, result back-pressure, watchdog and verdict.
// Depends on crsf_pkg, crsf_bench_pkg, crsf_channel_deframer_pwm_top and crsf_channel_deframer_pwm_checker.

module crsf_channel_deframer_pwm_top_test;

    import crsf_pkg::*;
    import crsf_bench_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 1900;
    localparam int PHASE_ITEMS = 240;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    in_item_t    item;
    logic        result_valid;
    logic        result_ready;
    out_item_t   result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          mismatches;
    int          pending;
    int          results_seen;
    int          frames_seen;
    int          failsafe_seen;

    int          send_busy_pct;
    int          recv_busy_pct;
    int          items_sent;
    int          settings_used;
    int          quiet_cycles;
    logic [7:0]  cur_sync;
    logic [7:0]  cur_kind;
    logic [15:0] cur_timeout;

    crsf_channel_deframer_pwm_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    crsf_channel_deframer_pwm_checker channel_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .mismatches    (mismatches),
        .pending       (pending),
        .results_seen  (results_seen),
        .frames_seen   (frames_seen),
        .failsafe_seen (failsafe_seen)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int draw_gap(input int busy_pct);
        if ($urandom_range(0, 99) < busy_pct)
            return $urandom_range(0, 18);
        return 0;
    endfunction

    function automatic logic [10:0] pick_channel();
        case ($urandom_range(0, 11))
            0:       return 11'd0;
            1:       return 11'd171;
            2:       return 11'd172;
            3:       return 11'd173;
            4:       return 11'd1810;
            5:       return 11'd1811;
            6:       return 11'd1812;
            7:       return 11'd2047;
            default: return 11'($urandom_range(0, 2047));
        endcase
    endfunction

    task automatic send_item(input logic f, input logic [7:0] b);
        int gap;
        gap = draw_gap(send_busy_pct);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= '{func: f, rx_byte: b};
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(FUNC_BYTE, b);
    endtask

    task automatic send_tick();
        send_item(FUNC_TICK, 8'($urandom));
    endtask

    // payload bytes carry the two channels little-endian; ticks may fall inside a frame
    task automatic send_frame(input logic [7:0] len, input logic [7:0] kind,
                              input logic [10:0] ch_a, input logic [10:0] ch_b,
                              input logic mix_ticks);
        logic [7:0] body [3];
        logic [1:0] spare;
        spare = 2'($urandom);
        body[0] = ch_a[7:0];
        body[1] = {ch_b[4:0], ch_a[10:8]};
        body[2] = {spare, ch_b[10:5]};
        send_byte(cur_sync);
        send_byte(len);
        send_byte(kind);
        for (int k = 0; k + 1 < len; k++)
        begin
            if (mix_ticks && $urandom_range(0, 9) == 0)
                send_tick();
            send_byte(k < 3 ? body[k] : 8'($urandom));
        end
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t r, input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        case (r)
            REG_SYNC:     cur_sync = v[7:0];
            REG_CHANNELS: cur_kind = v[7:0];
            REG_TIMEOUT:  cur_timeout = v[15:0];
            default:      ;
        endcase
    endtask

    task automatic random_traffic(input int count);
        int         stop_at;
        int         pick;
        int         burst;
        logic [7:0] len;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                len = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(4, 8))
                                                 : 8'($urandom_range(2, 28));
                send_frame(len, cur_kind, pick_channel(), pick_channel(), 1'b1);
            end
            else if (pick < 65)
                send_frame(8'($urandom_range(2, 28)), 8'($urandom),
                           pick_channel(), pick_channel(), 1'b1);
            else if (pick < 80)
            begin
                burst = (cur_timeout < 40) ? $urandom_range(1, cur_timeout + 4)
                                           : $urandom_range(1, 12);
                repeat (burst) send_tick();
            end
            else if (pick < 88)
                send_byte(8'($urandom));
            else if (pick < 94)
            begin
                send_byte(cur_sync);
                send_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 1))
                                               : 8'($urandom_range(29, 255)));
            end
            else
            begin
                // frame cut short; following bytes run into it
                len = 8'($urandom_range(4, 28));
                send_byte(cur_sync);
                send_byte(len);
                send_byte(cur_kind);
                repeat ($urandom_range(0, len - 2)) send_byte(8'($urandom));
            end
        end
    endtask

    initial
    begin : result_side
        int stall;
        result_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap(recv_busy_pct);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int         phase;
        int         random_start;
        logic [7:0] sync_val;
        logic [7:0] kind_val;
        logic [15:0] tmo_val;
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        quiet_cycles <= 0;
        items_sent = 0;
        settings_used = 1;
        cur_sync = 8'hC8;
        cur_kind = 8'h16;
        cur_timeout = 16'd500;
        send_busy_pct = 50;
        recv_busy_pct = 50;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: tick, stray byte, both bad lengths, channel extremes,
        // short channels frame, foreign frame type
        send_tick();
        send_byte(cur_sync ^ 8'h01);
        send_byte(cur_sync);
        send_byte(8'd1);
        send_byte(cur_sync);
        send_byte(8'd29);
        send_frame(8'd4, cur_kind, 11'd0, 11'd2047, 1'b0);
        send_frame(8'd4, cur_kind, 11'd2047, 11'd0, 1'b0);
        send_frame(8'd3, cur_kind, 11'd1000, 11'd1000, 1'b0);
        send_frame(8'd2, cur_kind ^ 8'h01, 11'd0, 11'd0, 1'b0);

        phase = 0;
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            settle();
            case (phase)
                0:
                begin
                    sync_val = 8'h00;
                    kind_val = 8'h00;
                    tmo_val = 16'h0000;
                end
                1:
                begin
                    sync_val = 8'hFF;
                    kind_val = 8'hFF;
                    tmo_val = 16'hFFFF;
                end
                default:
                begin
                    sync_val = 8'($urandom);
                    kind_val = 8'($urandom);
                    tmo_val = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 40));
                end
            endcase
            write_reg(REG_SYNC, {24'd0, sync_val});
            write_reg(REG_CHANNELS, {24'd0, kind_val});
            write_reg(REG_TIMEOUT, {16'd0, tmo_val});
            settings_used++;
            case ($urandom_range(0, 2))
                0:       send_busy_pct = 0;
                1:       send_busy_pct = 30;
                default: send_busy_pct = 100;
            endcase
            case ($urandom_range(0, 2))
                0:       recv_busy_pct = 0;
                1:       recv_busy_pct = 30;
                default: recv_busy_pct = 100;
            endcase
            random_traffic(PHASE_ITEMS);
            phase++;
        end

        settle();
        repeat (8) @(posedge clk);
        $display("Summary: %0d transactions under %0d register settings, %0d results checked",
                 items_sent, settings_used, results_seen);
        $display("Summary: %0d channel frames taken, %0d results in failsafe",
                 frames_seen, failsafe_seen);
        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
